// ===== hdl/tfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal package
// Widths, payload types and sideband types shared by the normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;
  localparam int NORM_ONE         = 1 << NORMAL_FRAC_BITS;

  localparam int EDGE_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * EDGE_BITS;
  localparam int CROSS_BITS  = PROD_BITS + 1;
  localparam int MAG_BITS    = CROSS_BITS - 1;
  localparam int POS_BITS    = $clog2(MAG_BITS + 1);
  localparam int TARGET_BITS = 30;
  localparam int SQ_BITS     = 2 * TARGET_BITS;
  localparam int SUM_BITS    = SQ_BITS + 2;
  localparam int LEN_BITS    = SUM_BITS / 2;
  localparam int QUO_BITS    = NORMAL_FRAC_BITS + 1;
  localparam int REM_BITS    = LEN_BITS + 1;
  localparam int NUM_BITS    = TARGET_BITS + NORMAL_FRAC_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
  } tfn_in_t;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic                          degenerate;
  } tfn_out_t;

  // Sign and degenerate flags of one triangle
  typedef struct packed {
    logic [2:0] neg;
    logic       degenerate;
  } tfn_sign_t;

  // Scaled magnitudes plus flags, carried alongside the square root
  typedef struct packed {
    logic [2:0][TARGET_BITS-1:0] r;
    tfn_sign_t                   sign;
  } tfn_sq_side_t;

  localparam int SIGN_SIDE_BITS = $bits(tfn_sign_t);
  localparam int SQ_SIDE_BITS   = $bits(tfn_sq_side_t);

endpackage

// ===== hdl/tfn_cross.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal: cross product
// Edges, six partial products and the exact cross product in three stages.
// ----------------------------------------------------------------------------
module tfn_cross (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  tfn_pkg::tfn_in_t                     tri_i,
  output logic                                 valid_o,
  output logic [2:0][tfn_pkg::CROSS_BITS-1:0]  cross_o
);
  import tfn_pkg::*;

  logic signed [EDGE_BITS-1:0] e1_d [3];
  logic signed [EDGE_BITS-1:0] e2_d [3];
  logic signed [EDGE_BITS-1:0] e1_q [3];
  logic signed [EDGE_BITS-1:0] e2_q [3];
  logic signed [PROD_BITS-1:0] p_d [6];
  logic signed [PROD_BITS-1:0] p_q [6];
  logic [2:0][CROSS_BITS-1:0]  cross_d, cross_q;
  logic [2:0]                  valid_q;

  always_comb begin
    e1_d[0] = EDGE_BITS'(tri_i.b_x) - EDGE_BITS'(tri_i.a_x);
    e1_d[1] = EDGE_BITS'(tri_i.b_y) - EDGE_BITS'(tri_i.a_y);
    e1_d[2] = EDGE_BITS'(tri_i.b_z) - EDGE_BITS'(tri_i.a_z);
    e2_d[0] = EDGE_BITS'(tri_i.c_x) - EDGE_BITS'(tri_i.b_x);
    e2_d[1] = EDGE_BITS'(tri_i.c_y) - EDGE_BITS'(tri_i.b_y);
    e2_d[2] = EDGE_BITS'(tri_i.c_z) - EDGE_BITS'(tri_i.b_z);
  end

  always_comb begin
    p_d[0] = PROD_BITS'(e1_q[1]) * PROD_BITS'(e2_q[2]);
    p_d[1] = PROD_BITS'(e1_q[2]) * PROD_BITS'(e2_q[1]);
    p_d[2] = PROD_BITS'(e1_q[2]) * PROD_BITS'(e2_q[0]);
    p_d[3] = PROD_BITS'(e1_q[0]) * PROD_BITS'(e2_q[2]);
    p_d[4] = PROD_BITS'(e1_q[0]) * PROD_BITS'(e2_q[1]);
    p_d[5] = PROD_BITS'(e1_q[1]) * PROD_BITS'(e2_q[0]);
  end

  always_comb begin
    cross_d[0] = CROSS_BITS'(p_q[0]) - CROSS_BITS'(p_q[1]);
    cross_d[1] = CROSS_BITS'(p_q[2]) - CROSS_BITS'(p_q[3]);
    cross_d[2] = CROSS_BITS'(p_q[4]) - CROSS_BITS'(p_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q    <= e1_d;
      e2_q    <= e2_d;
      p_q     <= p_d;
      cross_q <= cross_d;
    end
  end

  assign valid_o = valid_q[2];
  assign cross_o = cross_q;

endmodule

// ===== hdl/tfn_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal: normalise
// Sign split, leading-one search, common shift to 30 bits, squares and sum.
// ----------------------------------------------------------------------------
module tfn_norm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [2:0][tfn_pkg::CROSS_BITS-1:0] cross_i,
  output logic                                valid_o,
  output logic [tfn_pkg::SUM_BITS-1:0]        sum_o,
  output tfn_pkg::tfn_sq_side_t               side_o
);
  import tfn_pkg::*;

  logic [2:0][MAG_BITS-1:0]    mag_d, mag1_q, mag2_q;
  logic [CROSS_BITS-1:0]       neg_val [3];
  logic [2:0]                  neg_d, neg1_q, neg2_q;
  logic [MAG_BITS-1:0]         or_d, or_q;
  logic [POS_BITS-1:0]         top_d, top_q;
  logic [2:0][TARGET_BITS-1:0] r_d;
  tfn_sq_side_t                side3_d, side3_q, side4_q, side5_q;
  logic [SQ_BITS-1:0]          sq_d [3];
  logic [SQ_BITS-1:0]          sq_q [3];
  logic [SUM_BITS-1:0]         sum_d, sum_q;
  logic [4:0]                  valid_q;

  // Split sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_val[i] = -cross_i[i];
      neg_d[i]   = cross_i[i][CROSS_BITS-1];
      mag_d[i]   = neg_d[i] ? neg_val[i][MAG_BITS-1:0] : cross_i[i][MAG_BITS-1:0];
    end
    or_d = mag_d[0] | mag_d[1] | mag_d[2];
  end

  // Bit length of the largest magnitude
  always_comb begin
    top_d = '0;
    for (int i = 0; i < MAG_BITS; i++) begin
      if (or_q[i]) begin
        top_d = POS_BITS'(i + 1);
      end
    end
  end

  // Common shift: r = (m * 2^30) >> top
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_d[i] = TARGET_BITS'({mag2_q[i], {TARGET_BITS{1'b0}}} >> top_q);
    end
    side3_d.r               = r_d;
    side3_d.sign.neg        = neg2_q;
    side3_d.sign.degenerate = (top_q == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = SQ_BITS'(side3_q.r[i]) * SQ_BITS'(side3_q.r[i]);
    end
    sum_d = SUM_BITS'(sq_q[0]) + SUM_BITS'(sq_q[1]) + SUM_BITS'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      neg1_q  <= neg_d;
      or_q    <= or_d;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      top_q   <= top_d;
      side3_q <= side3_d;
      sq_q    <= sq_d;
      side4_q <= side3_q;
      sum_q   <= sum_d;
      side5_q <= side4_q;
    end
  end

  assign valid_o = valid_q[4];
  assign sum_o   = sum_q;
  assign side_o  = side5_q;

endmodule

// ===== hdl/tfn_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal: square root
// Floor square root, one root bit per pipeline stage, with sideband.
// ----------------------------------------------------------------------------
module tfn_sqrt #(
  parameter int SIDE_BITS = tfn_pkg::SQ_SIDE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [tfn_pkg::SUM_BITS-1:0]  sum_i,
  input  logic [SIDE_BITS-1:0]          side_i,
  output logic                          valid_o,
  output logic [tfn_pkg::LEN_BITS-1:0]  root_o,
  output logic [SIDE_BITS-1:0]          side_o
);
  import tfn_pkg::*;

  logic [SUM_BITS-1:0]  rem_s  [LEN_BITS+1];
  logic [LEN_BITS-1:0]  root_s [LEN_BITS+1];
  logic [SIDE_BITS-1:0] side_s [LEN_BITS+1];
  logic [LEN_BITS:0]    valid_s;

  assign rem_s[0]   = sum_i;
  assign root_s[0]  = '0;
  assign side_s[0]  = side_i;
  assign valid_s[0] = valid_i;

  for (genvar k = 0; k < LEN_BITS; k++) begin : g_stage
    localparam int B = LEN_BITS - 1 - k;
    logic [SUM_BITS-1:0]  trial;
    logic [SUM_BITS-1:0]  rem_d, rem_q;
    logic [LEN_BITS-1:0]  root_d, root_q;
    logic [SIDE_BITS-1:0] side_q;
    logic                 valid_q;

    // Try setting root bit B: needs rem >= root*2^(B+1) + 2^(2B)
    always_comb begin
      trial  = (SUM_BITS'(root_s[k]) << (B + 1)) | (SUM_BITS'(1) << (2 * B));
      rem_d  = rem_s[k];
      root_d = root_s[k];
      if (rem_s[k] >= trial) begin
        rem_d  = rem_s[k] - trial;
        root_d = root_s[k] | (LEN_BITS'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= valid_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]   = rem_q;
    assign root_s[k+1]  = root_q;
    assign side_s[k+1]  = side_q;
    assign valid_s[k+1] = valid_q;
  end

  assign valid_o = valid_s[LEN_BITS];
  assign root_o  = root_s[LEN_BITS];
  assign side_o  = side_s[LEN_BITS];

endmodule

// ===== hdl/tfn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal: divider
// Rounded quotient (r * 2^F + L/2) / L for three lanes, one bit per stage.
// ----------------------------------------------------------------------------
module tfn_div #(
  parameter int SIDE_BITS = tfn_pkg::SIGN_SIDE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [2:0][tfn_pkg::TARGET_BITS-1:0] r_i,
  input  logic [tfn_pkg::LEN_BITS-1:0]         len_i,
  input  logic [SIDE_BITS-1:0]                 side_i,
  output logic                                 valid_o,
  output logic [2:0][tfn_pkg::QUO_BITS-1:0]    quo_o,
  output logic [SIDE_BITS-1:0]                 side_o
);
  import tfn_pkg::*;

  logic [2:0][NUM_BITS-1:0] num_d, num_q;
  logic [LEN_BITS-1:0]      len_q;
  logic [SIDE_BITS-1:0]     side_q;
  logic                     valid_q;

  logic [2:0][REM_BITS-1:0] rem_s  [QUO_BITS+1];
  logic [2:0][QUO_BITS-1:0] lo_s   [QUO_BITS+1];
  logic [2:0][QUO_BITS-1:0] quo_s  [QUO_BITS+1];
  logic [LEN_BITS-1:0]      den_s  [QUO_BITS+1];
  logic [SIDE_BITS-1:0]     side_s [QUO_BITS+1];
  logic [QUO_BITS:0]        valid_s;

  // Form the rounded numerators
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NUM_BITS'(r_i[i]) << NORMAL_FRAC_BITS) + NUM_BITS'(len_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      len_q  <= len_i;
      side_q <= side_i;
    end
  end

  // Upper numerator bits are already below the divisor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_s[0][i] = REM_BITS'(num_q[i] >> QUO_BITS);
      lo_s[0][i]  = num_q[i][QUO_BITS-1:0];
    end
  end
  assign quo_s[0]   = '0;
  assign den_s[0]   = len_q;
  assign side_s[0]  = side_q;
  assign valid_s[0] = valid_q;

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    localparam int B = QUO_BITS - 1 - k;
    logic [2:0][REM_BITS-1:0] sh;
    logic [2:0][REM_BITS-1:0] rem_d, rem_q;
    logic [2:0][QUO_BITS-1:0] quo_d, quo_q, lo_q;
    logic [LEN_BITS-1:0]      den_q;
    logic [SIDE_BITS-1:0]     side_q;
    logic                     valid_q;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i]    = REM_BITS'({rem_s[k][i], lo_s[k][i][B]});
        rem_d[i] = sh[i];
        quo_d[i] = quo_s[k][i];
        if (sh[i] >= REM_BITS'(den_s[k])) begin
          rem_d[i]    = sh[i] - REM_BITS'(den_s[k]);
          quo_d[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= valid_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        lo_q   <= lo_s[k];
        den_q  <= den_s[k];
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]   = rem_q;
    assign quo_s[k+1]   = quo_q;
    assign lo_s[k+1]    = lo_q;
    assign den_s[k+1]   = den_q;
    assign side_s[k+1]  = side_q;
    assign valid_s[k+1] = valid_q;
  end

  assign valid_o = valid_s[QUO_BITS];
  assign quo_o   = quo_s[QUO_BITS];
  assign side_o  = side_s[QUO_BITS];

endmodule

// ===== hdl/triangle_face_normal.sv =====
// An accepted triangle passes through the cross product, normalise, square root
// and divide pipelines and then one output register to reach the output.
// Throughput: one triangle per cycle; the square root and divider are fully
// pipelined, one result bit per stage, and the whole pipeline holds on a stall.
// Reset clears every stage's valid bit; no payload register is reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal
// Unit normal of a triangle in signed Q1.14 from three Q8.8 vertices.
// ----------------------------------------------------------------------------
module triangle_face_normal (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfn_pkg::tfn_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfn_pkg::tfn_out_t out_data_o
);
  import tfn_pkg::*;

  // Pipeline enable: advance every stage unless the output transaction is held
  logic en;

  logic                       cross_valid;
  logic [2:0][CROSS_BITS-1:0] cross_prod;

  logic                norm_valid;
  logic [SUM_BITS-1:0] sum;
  tfn_sq_side_t        norm_side;

  logic                    sqrt_valid;
  logic [LEN_BITS-1:0]     root;
  logic [SQ_SIDE_BITS-1:0] sqrt_side_raw;
  tfn_sq_side_t            sqrt_side;

  logic                      div_valid;
  logic [2:0][QUO_BITS-1:0]  quo;
  logic [SIGN_SIDE_BITS-1:0] div_side_raw;
  tfn_sign_t                 div_side;

  logic                 out_valid_q;
  tfn_out_t             out_data_d, out_data_q;
  logic [NORMAL_BITS-1:0] comp [3];

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Edges and exact cross product
  tfn_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .tri_i   (in_data_i),
    .valid_o (cross_valid),
    .cross_o (cross_prod)
  );

  // Scale magnitudes to 30 bits and form the squared length
  tfn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cross_valid),
    .cross_i (cross_prod),
    .valid_o (norm_valid),
    .sum_o   (sum),
    .side_o  (norm_side)
  );

  // Length = floor(sqrt(sum)); scaled magnitudes ride along
  tfn_sqrt #(
    .SIDE_BITS (SQ_SIDE_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_valid),
    .sum_i   (sum),
    .side_i  (norm_side),
    .valid_o (sqrt_valid),
    .root_o  (root),
    .side_o  (sqrt_side_raw)
  );

  assign sqrt_side = tfn_sq_side_t'(sqrt_side_raw);

  // Rounded division of each component by the length
  tfn_div #(
    .SIDE_BITS (SIGN_SIDE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .r_i     (sqrt_side.r),
    .len_i   (root),
    .side_i  (sqrt_side.sign),
    .valid_o (div_valid),
    .quo_o   (quo),
    .side_o  (div_side_raw)
  );

  assign div_side = tfn_sign_t'(div_side_raw);

  // Apply signs; drop everything to zero for a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_side.degenerate) begin
        comp[i] = '0;
      end else if (div_side.neg[i]) begin
        comp[i] = -NORMAL_BITS'(quo[i]);
      end else begin
        comp[i] = NORMAL_BITS'(quo[i]);
      end
    end
    out_data_d.normal_x   = comp[0];
    out_data_d.normal_y   = comp[1];
    out_data_d.normal_z   = comp[2];
    out_data_d.degenerate = div_side.degenerate;
  end

  // Output register: hold the transaction while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // A degenerate triangle always reports a zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
      out_data_o.normal_z == '0)
    else $error("degenerate result with non-zero normal");

  // Every component stays within unit magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.normal_x <= NORM_ONE && out_data_o.normal_x >= -NORM_ONE &&
      out_data_o.normal_y <= NORM_ONE && out_data_o.normal_y >= -NORM_ONE &&
      out_data_o.normal_z <= NORM_ONE && out_data_o.normal_z >= -NORM_ONE)
    else $error("normal component exceeds unit magnitude");

  // Input side is only held back by a pending output transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output");
`endif

endmodule
